>>> design/cdss_pkg.sv
// ----------------------------------------------------------------------------
// cdss_pkg: shared types and constants for CD sector field slice selection
// Sector layouts, selection bit positions and track mode codes.
// ----------------------------------------------------------------------------
`default_nettype none

package cdss_pkg;

   typedef logic [2:0]  sector_type_type;
   typedef logic [2:0]  trk_mode_type;
   typedef logic [4:0]  field_select_type;
   typedef logic [11:0] byte_count_type;

   // Sector layout codes.
   localparam sector_type_type TYPE_FROM_TRACK = 3'd0;
   localparam sector_type_type TYPE_CDDA       = 3'd1;
   localparam sector_type_type TYPE_MODE1      = 3'd2;
   localparam sector_type_type TYPE_MODE2      = 3'd3;
   localparam sector_type_type TYPE_FORM1      = 3'd4;
   localparam sector_type_type TYPE_FORM2      = 3'd5;

   // Track mode codes.
   localparam trk_mode_type TRACK_AUDIO     = 3'd0;
   localparam trk_mode_type TRACK_CDG       = 3'd1;
   localparam trk_mode_type TRACK_MODE1_COOKED = 3'd2;
   localparam trk_mode_type TRACK_MODE1_RAW = 3'd3;

   // Fields in disc order.
   localparam int NUM_FIELDS = 5;
   localparam logic [2:0] FIELD_SYNC      = 3'd0;
   localparam logic [2:0] FIELD_HEADER    = 3'd1;
   localparam logic [2:0] FIELD_SUBHEADER = 3'd2;
   localparam logic [2:0] FIELD_DATA      = 3'd3;
   localparam logic [2:0] FIELD_EDC_ECC   = 3'd4;

   // Bit position of each field in the selection word.
   localparam logic [2:0] SEL_BIT_SYNC      = 3'd4;
   localparam logic [2:0] SEL_BIT_HEADER    = 3'd2;
   localparam logic [2:0] SEL_BIT_SUBHEADER = 3'd3;
   localparam logic [2:0] SEL_BIT_DATA      = 3'd1;
   localparam logic [2:0] SEL_BIT_EDC_ECC   = 3'd0;

   // Unknown sector type codes fall back to the Mode 1 layout; unknown track modes to Form 1.
   function automatic sector_type_type resolve_type(input sector_type_type stype,
                                                    input trk_mode_type tmode);
      sector_type_type res;
      case (stype)
         TYPE_FROM_TRACK: begin
            case (tmode)
               TRACK_AUDIO, TRACK_CDG:               res = TYPE_CDDA;
               TRACK_MODE1_COOKED, TRACK_MODE1_RAW:  res = TYPE_MODE1;
               default:                              res = TYPE_FORM1;
            endcase
         end
         TYPE_CDDA, TYPE_MODE1, TYPE_MODE2, TYPE_FORM1, TYPE_FORM2: res = stype;
         default: res = TYPE_MODE1;
      endcase
      return res;
   endfunction

   function automatic logic [2:0] select_bit(input logic [2:0] field);
      logic [2:0] pos;
      case (field)
         FIELD_SYNC:      pos = SEL_BIT_SYNC;
         FIELD_HEADER:    pos = SEL_BIT_HEADER;
         FIELD_SUBHEADER: pos = SEL_BIT_SUBHEADER;
         FIELD_DATA:      pos = SEL_BIT_DATA;
         default:         pos = SEL_BIT_EDC_ECC;
      endcase
      return pos;
   endfunction

   // Byte size of one field for a resolved layout.
   function automatic byte_count_type field_size(input sector_type_type stype,
                                                 input logic [2:0] field);
      byte_count_type sz;
      if (stype == TYPE_CDDA) begin
         sz = (field == FIELD_DATA) ? 12'd2352 : 12'd0;
      end else begin
         case (field)
            FIELD_SYNC:      sz = 12'd12;
            FIELD_HEADER:    sz = 12'd4;
            FIELD_SUBHEADER: sz = (stype == TYPE_FORM1 || stype == TYPE_FORM2) ? 12'd8 : 12'd0;
            FIELD_DATA: begin
               case (stype)
                  TYPE_MODE2: sz = 12'd2336;
                  TYPE_FORM2: sz = 12'd2324;
                  default:    sz = 12'd2048;
               endcase
            end
            default: begin
               case (stype)
                  TYPE_MODE2: sz = 12'd0;
                  TYPE_FORM1: sz = 12'd280;
                  TYPE_FORM2: sz = 12'd4;
                  default:    sz = 12'd288;
               endcase
            end
         endcase
      end
      return sz;
   endfunction

endpackage

`default_nettype wire

>>> design/cd_sector_field_slice_select.sv
// ----------------------------------------------------------------------------
// cd_sector_field_slice_select: READ CD main channel slice decode
// Resolves the sector layout and returns length, start offset and run flag.
// ----------------------------------------------------------------------------
//  Channel  Direction  Handshake              Payload
//  req_     in         req_valid/req_ready    sector_type, trk_mode, field_select
//  rsp_     out        rsp_valid/rsp_ready    resolved_type, transfer_length,
//                                             start_offset, contiguous
//
// Two register stages: the request is captured in an input register and the
// decoded result in an output register, and one transaction is accepted per
// cycle while rsp_ready does not stall. A stall on rsp_ready holds both stages,
// and req_ready drops only when both are full. Reset empties both stages.
// ----------------------------------------------------------------------------
`default_nettype none

module cd_sector_field_slice_select (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_valid,
   output logic             req_ready,
   input  wire logic [2:0]  req_sector_type,
   input  wire logic [2:0]  req_trk_mode,
   input  wire logic [4:0]  req_field_select,
   output logic             rsp_valid,
   input  wire logic        rsp_ready,
   output logic [2:0]       rsp_resolved_type,
   output logic [11:0]      rsp_transfer_length,
   output logic [11:0]      rsp_start_offset,
   output logic             rsp_contiguous
);

   logic                        in_valid_ff, in_valid_in;
   cdss_pkg::sector_type_type   in_stype_ff;
   cdss_pkg::trk_mode_type      in_tmode_ff;
   cdss_pkg::field_select_type  in_sel_ff;

   logic                        out_valid_ff, out_valid_in;
   cdss_pkg::sector_type_type   out_type_ff;
   cdss_pkg::byte_count_type    out_length_ff;
   cdss_pkg::byte_count_type    out_offset_ff;
   logic                        out_contig_ff;

   logic                        out_load;
   logic                        in_load;

   cdss_pkg::sector_type_type   calc_type;
   cdss_pkg::byte_count_type    calc_length;
   cdss_pkg::byte_count_type    calc_offset;
   logic                        calc_contig;

   assign out_load  = in_valid_ff && (!out_valid_ff || rsp_ready);
   assign req_ready = !in_valid_ff || out_load;
   assign in_load   = req_valid && req_ready;

   assign in_valid_in  = in_load || (in_valid_ff && !out_load);
   assign out_valid_in = out_load || (out_valid_ff && !rsp_ready);

   // Walk the five fields in disc order; absent fields neither serve nor split.
   always_comb begin
      logic [2:0]                f;
      cdss_pkg::byte_count_type  sz;
      logic                      picked;
      logic                      found;
      logic                      started;
      logic                      ended;
      calc_type   = cdss_pkg::resolve_type(in_stype_ff, in_tmode_ff);
      calc_length = '0;
      calc_offset = '0;
      calc_contig = 1'b1;
      found       = 1'b0;
      started     = 1'b0;
      ended       = 1'b0;
      for (int i = 0; i < cdss_pkg::NUM_FIELDS; i++) begin
         f      = 3'(i);
         sz     = cdss_pkg::field_size(calc_type, f);
         picked = in_sel_ff[cdss_pkg::select_bit(f)];
         if (picked) begin
            calc_length = calc_length + sz;
         end
         if (sz != '0) begin
            if (picked) begin
               found = 1'b1;
               if (ended) begin
                  calc_contig = 1'b0;
               end
               started = 1'b1;
            end else begin
               if (!found) begin
                  calc_offset = calc_offset + sz;
               end
               if (started) begin
                  ended = 1'b1;
               end
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         in_valid_ff  <= in_valid_in;
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (in_load) begin
         in_stype_ff <= req_sector_type;
         in_tmode_ff <= req_trk_mode;
         in_sel_ff   <= req_field_select;
      end
      if (out_load) begin
         out_type_ff   <= calc_type;
         out_length_ff <= calc_length;
         out_offset_ff <= calc_offset;
         out_contig_ff <= calc_contig;
      end
   end

   assign rsp_valid           = out_valid_ff;
   assign rsp_resolved_type   = out_type_ff;
   assign rsp_transfer_length = out_length_ff;
   assign rsp_start_offset    = out_offset_ff;
   assign rsp_contiguous      = out_contig_ff;

endmodule

`default_nettype wire

>>> tb/sv/slice_select_checker.sv
// ----------------------------------------------------------------------------
// slice_select_checker: response checker for the READ CD slice decoder
// Watches both channels, predicts the layout, length, offset and run flag of
// every accepted request, and compares each response in order.
// ----------------------------------------------------------------------------
module slice_select_checker (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       req_valid,
   input  logic                       req_ready,
   input  cdss_pkg::sector_type_type  req_sector_type,
   input  cdss_pkg::trk_mode_type     req_trk_mode,
   input  cdss_pkg::field_select_type req_field_select,
   input  logic                       rsp_valid,
   input  logic                       rsp_ready,
   input  cdss_pkg::sector_type_type  rsp_resolved_type,
   input  cdss_pkg::byte_count_type   rsp_transfer_length,
   input  cdss_pkg::byte_count_type   rsp_start_offset,
   input  logic                       rsp_contiguous,
   output int                         mismatch_count,
   output int                         checked_count,
   output int                         pending_count
);

   typedef struct packed {
      cdss_pkg::sector_type_type layout;
      cdss_pkg::byte_count_type  length;
      cdss_pkg::byte_count_type  offset;
      logic                      contig;
   } slice_result_type;

   slice_result_type expected_slices[$];
   int               errors = 0;
   int               checked = 0;

   initial begin
      mismatch_count = 0;
      checked_count  = 0;
      pending_count  = 0;
   end

   function automatic slice_result_type decode_slice(
         input cdss_pkg::sector_type_type  stype,
         input cdss_pkg::trk_mode_type     tmode,
         input cdss_pkg::field_select_type sel);
      slice_result_type         r;
      cdss_pkg::byte_count_type sizes [5];
      logic [4:0]               picked;
      logic                     found;
      logic                     started;
      logic                     ended;
      if (stype == cdss_pkg::TYPE_FROM_TRACK) begin
         if (tmode == cdss_pkg::TRACK_AUDIO || tmode == cdss_pkg::TRACK_CDG)
            r.layout = cdss_pkg::TYPE_CDDA;
         else if (tmode == cdss_pkg::TRACK_MODE1_COOKED ||
                  tmode == cdss_pkg::TRACK_MODE1_RAW)
            r.layout = cdss_pkg::TYPE_MODE1;
         else
            r.layout = cdss_pkg::TYPE_FORM1;
      end else if (stype <= cdss_pkg::TYPE_FORM2) begin
         r.layout = stype;
      end else begin
         r.layout = cdss_pkg::TYPE_MODE1;
      end
      // Sizes in disc order: sync, header, subheader, user data, EDC/ECC.
      case (r.layout)
         cdss_pkg::TYPE_CDDA:  sizes = '{12'd0,  12'd0, 12'd0, 12'd2352, 12'd0};
         cdss_pkg::TYPE_MODE2: sizes = '{12'd12, 12'd4, 12'd0, 12'd2336, 12'd0};
         cdss_pkg::TYPE_FORM1: sizes = '{12'd12, 12'd4, 12'd8, 12'd2048, 12'd280};
         cdss_pkg::TYPE_FORM2: sizes = '{12'd12, 12'd4, 12'd8, 12'd2324, 12'd4};
         default:              sizes = '{12'd12, 12'd4, 12'd0, 12'd2048, 12'd288};
      endcase
      picked = {sel[cdss_pkg::SEL_BIT_EDC_ECC], sel[cdss_pkg::SEL_BIT_DATA],
                sel[cdss_pkg::SEL_BIT_SUBHEADER], sel[cdss_pkg::SEL_BIT_HEADER],
                sel[cdss_pkg::SEL_BIT_SYNC]};
      r.length = '0;
      r.offset = '0;
      r.contig = 1'b1;
      found    = 1'b0;
      started  = 1'b0;
      ended    = 1'b0;
      for (int i = 0; i < 5; i++) begin
         if (picked[i])
            r.length = r.length + sizes[i];
         // An absent field neither ends a run nor counts toward the offset.
         if (sizes[i] != 0) begin
            if (picked[i]) begin
               found = 1'b1;
               if (ended)
                  r.contig = 1'b0;
               started = 1'b1;
            end else begin
               if (!found)
                  r.offset = r.offset + sizes[i];
               if (started)
                  ended = 1'b1;
            end
         end
      end
      return r;
   endfunction

   task automatic compare_field(input string name, input int want, input int got);
      if (want != got) begin
         $display("%0t: %s mismatch: expected %0d, actual %0d", $time, name, want, got);
         errors++;
      end
   endtask

   always @(posedge clock) begin : monitor
      slice_result_type want;
      if (!reset) begin
         if (rsp_valid && rsp_ready) begin
            if (expected_slices.size() == 0) begin
               $display("%0t: response transaction with no request outstanding", $time);
               errors++;
            end else begin
               want = expected_slices.pop_front();
               checked++;
               compare_field("resolved_type", want.layout, rsp_resolved_type);
               compare_field("transfer_length", want.length, rsp_transfer_length);
               compare_field("start_offset", want.offset, rsp_start_offset);
               compare_field("contiguous", want.contig, rsp_contiguous);
            end
         end
         if (req_valid && req_ready)
            expected_slices.push_back(decode_slice(req_sector_type, req_trk_mode,
                                                   req_field_select));
      end
      mismatch_count <= errors;
      checked_count  <= checked;
      pending_count  <= expected_slices.size();
   end

endmodule

>>> tb/sv/testbench.sv
// ----------------------------------------------------------------------------
// testbench: top level for the READ CD slice decoder
// Drives directed and random requests under changing idle profiles and one
// long response stall; the checker beside the block predicts and compares.
// ----------------------------------------------------------------------------
module testbench;

   localparam int RANDOM_PER_PROFILE = 400;
   localparam int LONG_STALL_CYCLES  = 64;

   logic                       clock = 1'b0;
   logic                       reset;
   logic                       req_valid;
   logic                       req_ready;
   cdss_pkg::sector_type_type  req_sector_type;
   cdss_pkg::trk_mode_type     req_trk_mode;
   cdss_pkg::field_select_type req_field_select;
   logic                       rsp_valid;
   logic                       rsp_ready;
   cdss_pkg::sector_type_type  rsp_resolved_type;
   cdss_pkg::byte_count_type   rsp_transfer_length;
   cdss_pkg::byte_count_type   rsp_start_offset;
   logic                       rsp_contiguous;

   int   mismatch_count;
   int   checked_count;
   int   pending_count;
   int   requests_sent = 0;
   int   send_idle_pct = 17;
   int   recv_idle_pct;
   logic long_stall_req;

   always #5 clock = ~clock;

   cd_sector_field_slice_select u_dut (
      .clock               (clock),
      .reset               (reset),
      .req_valid           (req_valid),
      .req_ready           (req_ready),
      .req_sector_type     (req_sector_type),
      .req_trk_mode        (req_trk_mode),
      .req_field_select    (req_field_select),
      .rsp_valid           (rsp_valid),
      .rsp_ready           (rsp_ready),
      .rsp_resolved_type   (rsp_resolved_type),
      .rsp_transfer_length (rsp_transfer_length),
      .rsp_start_offset    (rsp_start_offset),
      .rsp_contiguous      (rsp_contiguous)
   );

   slice_select_checker u_checker (
      .clock               (clock),
      .reset               (reset),
      .req_valid           (req_valid),
      .req_ready           (req_ready),
      .req_sector_type     (req_sector_type),
      .req_trk_mode        (req_trk_mode),
      .req_field_select    (req_field_select),
      .rsp_valid           (rsp_valid),
      .rsp_ready           (rsp_ready),
      .rsp_resolved_type   (rsp_resolved_type),
      .rsp_transfer_length (rsp_transfer_length),
      .rsp_start_offset    (rsp_start_offset),
      .rsp_contiguous      (rsp_contiguous),
      .mismatch_count      (mismatch_count),
      .checked_count       (checked_count),
      .pending_count       (pending_count)
   );

   // Response side: random back-pressure, plus one long hold-off on request.
   initial begin : response_sink
      int   hold_left;
      logic hold_done;
      hold_left = 0;
      hold_done = 1'b0;
      rsp_ready <= 1'b0;
      forever begin
         @(posedge clock);
         if (long_stall_req && !hold_done) begin
            hold_left = LONG_STALL_CYCLES;
            hold_done = 1'b1;
         end
         if (hold_left > 0) begin
            rsp_ready <= 1'b0;
            hold_left--;
         end else begin
            rsp_ready <= ($urandom_range(99) >= recv_idle_pct);
         end
      end
   end

   task automatic send_request(input cdss_pkg::sector_type_type  stype,
                               input cdss_pkg::trk_mode_type     tmode,
                               input cdss_pkg::field_select_type sel);
      while ($urandom_range(99) < send_idle_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid        <= 1'b1;
      req_sector_type  <= stype;
      req_trk_mode     <= tmode;
      req_field_select <= sel;
      @(posedge clock);
      while (!req_ready)
         @(posedge clock);
      requests_sent++;
   endtask

   task automatic send_random_request();
      cdss_pkg::trk_mode_type tmode;
      // Mostly track codes 0 to 4 (the defined modes and one undefined code), now and then codes 5 to 7.
      if ($urandom_range(9) == 0)
         tmode = cdss_pkg::trk_mode_type'($urandom_range(5, 7));
      else
         tmode = cdss_pkg::trk_mode_type'($urandom_range(0, 4));
      send_request(cdss_pkg::sector_type_type'($urandom_range(0, 7)), tmode,
                   cdss_pkg::field_select_type'($urandom_range(0, 31)));
   endtask

   initial begin : stimulus
      int failures;
      reset            <= 1'b1;
      req_valid        <= 1'b0;
      req_sector_type  <= cdss_pkg::TYPE_FROM_TRACK;
      req_trk_mode     <= cdss_pkg::TRACK_AUDIO;
      req_field_select <= '0;
      recv_idle_pct    <= 47;
      long_stall_req   <= 1'b0;
      repeat (5) @(posedge clock);
      reset <= 1'b0;

      // Every track mode code, with the layout derived from the track.
      for (int m = 0; m < 8; m++)
         send_request(cdss_pkg::TYPE_FROM_TRACK, cdss_pkg::trk_mode_type'(m), '1);
      // Every explicit sector type, with nothing and with everything selected.
      for (int s = cdss_pkg::TYPE_CDDA; s <= 7; s++) begin
         send_request(cdss_pkg::sector_type_type'(s), cdss_pkg::TRACK_MODE1_RAW, '0);
         send_request(cdss_pkg::sector_type_type'(s), cdss_pkg::TRACK_AUDIO, '1);
      end
      // Only an absent field selected, a run split by a gap, and a split
      // across the subheader and user data of a Form 2 sector.
      send_request(cdss_pkg::TYPE_MODE1, cdss_pkg::TRACK_AUDIO,
                   cdss_pkg::field_select_type'(1 << cdss_pkg::SEL_BIT_SUBHEADER));
      send_request(cdss_pkg::TYPE_MODE1, cdss_pkg::TRACK_CDG,
                   cdss_pkg::field_select_type'((1 << cdss_pkg::SEL_BIT_SYNC) |
                                                (1 << cdss_pkg::SEL_BIT_DATA)));
      send_request(cdss_pkg::TYPE_FORM2, cdss_pkg::TRACK_AUDIO,
                   cdss_pkg::field_select_type'((1 << cdss_pkg::SEL_BIT_HEADER) |
                                                (1 << cdss_pkg::SEL_BIT_EDC_ECC)));

      for (int n = 0; n < RANDOM_PER_PROFILE; n++)
         send_random_request();

      send_idle_pct = 47;
      recv_idle_pct <= 17;
      for (int n = 0; n < RANDOM_PER_PROFILE; n++)
         send_random_request();

      send_idle_pct = 0;
      recv_idle_pct <= 0;
      long_stall_req <= 1'b1;
      for (int n = 0; n < RANDOM_PER_PROFILE; n++)
         send_random_request();
      req_valid <= 1'b0;

      while (checked_count < requests_sent)
         @(posedge clock);
      repeat (8) @(posedge clock);

      failures = mismatch_count + pending_count;
      $display("Summary: %0d requests, directed type and track codes then random,",
               requests_sent);
      $display("  under three idle profiles and a %0d-cycle response stall; %0d checked.",
               LONG_STALL_CYCLES, checked_count);
      if (failures == 0)
         $display("Verification passed");
      else
         $display("Verification failed");
      $finish;
   end

   initial begin : watchdog
      #2000000;
      $display("Verification failed");
      $finish;
   end

endmodule
